### design/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared sizes, register indexes and widths of the box mean filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

  localparam int MAX_KERNEL = 7;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // fixed field widths
  localparam int KS_W       = 3;
  localparam int IW_W       = 11;
  localparam int IH_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int PIX_W      = 8;

  // derived sizes
  localparam int KC_W     = 4;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT) + 1;
  localparam int EW_W     = $clog2(MAX_WIDTH + 1);
  localparam int EH_W     = $clog2(MAX_HEIGHT + 1);
  localparam int SLOT_W   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int ADDR_W   = SLOT_W + COL_W;
  localparam int RAM_DEPTH = MAX_KERNEL * (1 << COL_W);
  localparam int SUM_W    = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
  localparam int DIV_W    = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int LIN_W    = ROW_W + EW_W + 1;
  localparam int MODC_W   = $clog2(ROW_W + 1);
  localparam int DIVC_W   = $clog2(SUM_W + 1);

  localparam logic [KC_W-1:0] K_ODD_MAX = KC_W'((MAX_KERNEL - 1) | 1);

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

endpackage

### design/bmf_pix_in_if.sv
// ----------------------------------------------------------------------------
// bmf_pix_in_if
// Input word channel: op code and raster pixel.
// ----------------------------------------------------------------------------
interface bmf_pix_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [bmf_pkg::PIX_W-1:0]  pixel_in;

  modport source (output valid, output op, output pixel_in, input ready);
  modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

### design/bmf_pix_out_if.sv
// ----------------------------------------------------------------------------
// bmf_pix_out_if
// Result word channel: filtered pixel and end-of-frame flag.
// ----------------------------------------------------------------------------
interface bmf_pix_out_if;
  logic                       valid;
  logic                       ready;
  logic [bmf_pkg::PIX_W-1:0]  pixel_out;
  logic                       frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

### design/bmf_cfg_if.sv
// ----------------------------------------------------------------------------
// bmf_cfg_if
// Configuration write channel: register index and data.
// ----------------------------------------------------------------------------
interface bmf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bmf_pkg::CFG_IDX_W-1:0]   index;
  logic [bmf_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/bmf_ram.sv
// ----------------------------------------------------------------------------
// bmf_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module bmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### design/box_mean_filter.sv
// ----------------------------------------------------------------------------
// box_mean_filter
// k-by-k box mean filter over an 8-bit raster stream, row store in RAM.
// ----------------------------------------------------------------------------
// Channels: pixels (op, pixel_in) in, results (pixel_out, frame_last) out,
// cfg writes kernel_size (0), image_width (1), image_height (2); cfg is
// always ready; the user must see that it is written only while the block
// is idle, as the block itself does not enforce this. One word is worked
// at a time: a new word is accepted only in idle, once the last one is
// through. A word's time is set by the 13-step row modulo, one row store
// read per window cell (k*k cells for an interior pixel, 1 for an edge
// pixel) and the 14-step divider.
// Results land in an output register; a stalled receiver holds the block
// in its final step until that register is free.
// Reset clears the counters, loads k=3, 512 by 512, and empties the
// output register; the row store is not cleared.
// ----------------------------------------------------------------------------
module box_mean_filter (
  input  logic           clk,
  input  logic           rst,
  bmf_cfg_if.sink        cfg,
  bmf_pix_in_if.sink     pixels,
  bmf_pix_out_if.source  results
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DECIDE, S_MOD, S_WRITE, S_CHECK,
    S_EPREP, S_RD, S_RDW, S_DIV, S_OUT
  } state_t;

  state_t state;

  logic [bmf_pkg::KS_W-1:0]   ks;
  logic [bmf_pkg::IW_W-1:0]   iw;
  logic [bmf_pkg::IH_W-1:0]   ih;

  logic [bmf_pkg::KC_W-1:0]   eff_k;
  logic [bmf_pkg::KC_W-1:0]   ks_odd;
  logic [bmf_pkg::KC_W-1:0]   h;
  logic [bmf_pkg::EW_W-1:0]   eff_w;
  logic [bmf_pkg::EH_W-1:0]   eff_h;

  logic [bmf_pkg::COL_W-1:0]  in_col;
  logic [bmf_pkg::ROW_W-1:0]  in_row;
  logic [bmf_pkg::COL_W-1:0]  out_col;
  logic [bmf_pkg::ROW_W-1:0]  out_row;

  logic                       op_q;
  logic [bmf_pkg::PIX_W-1:0]  pix_q;

  logic [bmf_pkg::LIN_W-1:0]  in_mul;
  logic [bmf_pkg::LIN_W-1:0]  out_mul;
  logic [bmf_pkg::LIN_W-1:0]  tot;
  logic [bmf_pkg::LIN_W-1:0]  hw;
  logic [bmf_pkg::LIN_W-1:0]  new_lin;
  logic [bmf_pkg::LIN_W-1:0]  in_lin;
  logic                       complete;

  logic [bmf_pkg::ROW_W-1:0]  mod_val;
  logic [bmf_pkg::MODC_W-1:0] mod_cnt;
  logic [bmf_pkg::KC_W-1:0]   mod_rem;
  logic                       mod_wr;
  logic [bmf_pkg::KC_W:0]     rem_sh;
  logic [bmf_pkg::KC_W-1:0]   rem_nx;

  logic                       interior;
  logic [bmf_pkg::KC_W-1:0]   win_n;
  logic [bmf_pkg::COL_W-1:0]  col_base;
  logic [bmf_pkg::SLOT_W-1:0] slot;
  logic [bmf_pkg::KC_W-1:0]   dr;
  logic [bmf_pkg::KC_W-1:0]   dc;
  logic                       rd_pend;
  logic [bmf_pkg::SUM_W-1:0]  sum;

  logic [bmf_pkg::DIV_W-1:0]  divisor;
  logic [bmf_pkg::SUM_W-1:0]  div_q;
  logic [bmf_pkg::DIV_W-1:0]  div_r;
  logic [bmf_pkg::DIVC_W-1:0] div_cnt;
  logic [bmf_pkg::DIV_W:0]    div_sh;

  logic                       wrap;
  logic                       last;

  logic                       ram_we;
  logic [bmf_pkg::ADDR_W-1:0] ram_addr;
  logic [bmf_pkg::PIX_W-1:0]  ram_rdata;

  // effective configuration
  always_comb begin
    ks_odd = bmf_pkg::KC_W'(ks) | bmf_pkg::KC_W'(1);
    eff_k  = (ks_odd > bmf_pkg::K_ODD_MAX) ? bmf_pkg::K_ODD_MAX : ks_odd;
    h      = eff_k >> 1;
    if (iw == '0) begin
      eff_w = bmf_pkg::EW_W'(1);
    end else if (32'(iw) > bmf_pkg::MAX_WIDTH) begin
      eff_w = bmf_pkg::EW_W'(bmf_pkg::MAX_WIDTH);
    end else begin
      eff_w = bmf_pkg::EW_W'(iw);
    end
    if (ih == '0) begin
      eff_h = bmf_pkg::EH_W'(1);
    end else if (32'(ih) > bmf_pkg::MAX_HEIGHT) begin
      eff_h = bmf_pkg::EH_W'(bmf_pkg::MAX_HEIGHT);
    end else begin
      eff_h = bmf_pkg::EH_W'(ih);
    end
  end

  always_comb begin
    in_lin   = in_mul + bmf_pkg::LIN_W'(in_col);
    complete = in_lin >= tot;
    rem_sh   = {mod_rem, mod_val[bmf_pkg::ROW_W-1]};
    rem_nx   = (rem_sh >= (bmf_pkg::KC_W+1)'(eff_k)) ?
               bmf_pkg::KC_W'(rem_sh - (bmf_pkg::KC_W+1)'(eff_k)) :
               bmf_pkg::KC_W'(rem_sh);
    interior = (out_row >= bmf_pkg::ROW_W'(h)) &&
               (({1'b0, out_row} + (bmf_pkg::ROW_W+1)'(h)) <
                (bmf_pkg::ROW_W+1)'(eff_h)) &&
               ((bmf_pkg::COL_W+1)'(out_col) >= (bmf_pkg::COL_W+1)'(h)) &&
               (((bmf_pkg::EW_W+1)'(out_col) + (bmf_pkg::EW_W+1)'(h)) <
                (bmf_pkg::EW_W+1)'(eff_w));
    divisor  = bmf_pkg::DIV_W'(win_n) * bmf_pkg::DIV_W'(win_n);
    div_sh   = {div_r, div_q[bmf_pkg::SUM_W-1]};
    wrap     = (bmf_pkg::EW_W+1)'(in_col) + (bmf_pkg::EW_W+1)'(1) >=
               (bmf_pkg::EW_W+1)'(eff_w);
    last     = out_mul + bmf_pkg::LIN_W'(out_col) + bmf_pkg::LIN_W'(1) >= tot;
  end

  always_comb begin
    ram_we = (state == S_WRITE);
    if (state == S_WRITE) begin
      ram_addr = {bmf_pkg::SLOT_W'(mod_rem), in_col};
    end else begin
      ram_addr = {slot, col_base + bmf_pkg::COL_W'(dc)};
    end
  end

  bmf_ram #(
    .WIDTH (bmf_pkg::PIX_W),
    .DEPTH (bmf_pkg::RAM_DEPTH)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (pix_q),
    .rdata (ram_rdata)
  );

  assign cfg.ready    = 1'b1;
  assign pixels.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ks            <= bmf_pkg::KS_W'(3);
      iw            <= bmf_pkg::IW_W'(512);
      ih            <= bmf_pkg::IH_W'(512);
      in_col        <= '0;
      in_row        <= '0;
      out_col       <= '0;
      out_row       <= '0;
      results.valid <= 1'b0;
      rd_pend       <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          bmf_pkg::REG_KERNEL: ks <= cfg.data[bmf_pkg::KS_W-1:0];
          bmf_pkg::REG_WIDTH:  iw <= cfg.data[bmf_pkg::IW_W-1:0];
          bmf_pkg::REG_HEIGHT: ih <= cfg.data[bmf_pkg::IH_W-1:0];
          default: ;
        endcase
      end
      if (results.ready && state != S_OUT) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pixels.valid) begin
            op_q  <= pixels.op;
            pix_q <= pixels.pixel_in;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          in_mul  <= bmf_pkg::LIN_W'(in_row) * bmf_pkg::LIN_W'(eff_w);
          out_mul <= bmf_pkg::LIN_W'(out_row) * bmf_pkg::LIN_W'(eff_w);
          tot     <= bmf_pkg::LIN_W'(eff_w) * bmf_pkg::LIN_W'(eff_h);
          hw      <= bmf_pkg::LIN_W'(h) * bmf_pkg::LIN_W'(eff_w);
          state   <= S_DECIDE;
        end
        S_DECIDE: begin
          if (!op_q && !complete) begin
            mod_val <= in_row;
            mod_cnt <= bmf_pkg::MODC_W'(bmf_pkg::ROW_W);
            mod_rem <= '0;
            mod_wr  <= 1'b1;
            state   <= S_MOD;
          end else if (complete) begin
            state <= S_EPREP;
          end else begin
            state <= S_IDLE;
          end
        end
        S_MOD: begin
          mod_rem <= rem_nx;
          mod_val <= mod_val << 1;
          mod_cnt <= mod_cnt - bmf_pkg::MODC_W'(1);
          if (mod_cnt == bmf_pkg::MODC_W'(1)) begin
            slot    <= bmf_pkg::SLOT_W'(rem_nx);
            dr      <= '0;
            dc      <= '0;
            sum     <= '0;
            rd_pend <= 1'b0;
            state   <= mod_wr ? S_WRITE : S_RD;
          end
        end
        S_WRITE: begin
          if (wrap) begin
            in_col  <= '0;
            in_row  <= in_row + bmf_pkg::ROW_W'(1);
            new_lin <= in_mul + bmf_pkg::LIN_W'(eff_w);
          end else begin
            in_col  <= in_col + bmf_pkg::COL_W'(1);
            new_lin <= in_lin + bmf_pkg::LIN_W'(1);
          end
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (new_lin > out_mul + bmf_pkg::LIN_W'(out_col) + hw + bmf_pkg::LIN_W'(h)) begin
            state <= S_EPREP;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EPREP: begin
          win_n    <= interior ? eff_k : bmf_pkg::KC_W'(1);
          mod_val  <= interior ? out_row - bmf_pkg::ROW_W'(h) : out_row;
          col_base <= interior ? out_col - bmf_pkg::COL_W'(h) : out_col;
          mod_cnt  <= bmf_pkg::MODC_W'(bmf_pkg::ROW_W);
          mod_rem  <= '0;
          mod_wr   <= 1'b0;
          state    <= S_MOD;
        end
        S_RD: begin
          rd_pend <= 1'b1;
          if (rd_pend) begin
            sum <= sum + bmf_pkg::SUM_W'(ram_rdata);
          end
          if (dc == win_n - bmf_pkg::KC_W'(1)) begin
            dc <= '0;
            dr <= dr + bmf_pkg::KC_W'(1);
            if (bmf_pkg::KC_W'(slot) + bmf_pkg::KC_W'(1) == eff_k) begin
              slot <= '0;
            end else begin
              slot <= slot + bmf_pkg::SLOT_W'(1);
            end
            if (dr == win_n - bmf_pkg::KC_W'(1)) begin
              state <= S_RDW;
            end
          end else begin
            dc <= dc + bmf_pkg::KC_W'(1);
          end
        end
        S_RDW: begin
          rd_pend <= 1'b0;
          div_q   <= sum + bmf_pkg::SUM_W'(ram_rdata);
          div_r   <= '0;
          div_cnt <= bmf_pkg::DIVC_W'(bmf_pkg::SUM_W);
          state   <= S_DIV;
        end
        S_DIV: begin
          if (div_sh >= {1'b0, divisor}) begin
            div_r <= bmf_pkg::DIV_W'(div_sh - {1'b0, divisor});
            div_q <= {div_q[bmf_pkg::SUM_W-2:0], 1'b1};
          end else begin
            div_r <= bmf_pkg::DIV_W'(div_sh);
            div_q <= {div_q[bmf_pkg::SUM_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt - bmf_pkg::DIVC_W'(1);
          if (div_cnt == bmf_pkg::DIVC_W'(1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!results.valid || results.ready) begin
            results.valid      <= 1'b1;
            results.pixel_out  <= div_q[bmf_pkg::PIX_W-1:0];
            results.frame_last <= last;
            if (last) begin
              in_col  <= '0;
              in_row  <= '0;
              out_col <= '0;
              out_row <= '0;
            end else if ((bmf_pkg::EW_W+1)'(out_col) + (bmf_pkg::EW_W+1)'(1) >=
                         (bmf_pkg::EW_W+1)'(eff_w)) begin
              out_col <= '0;
              out_row <= out_row + bmf_pkg::ROW_W'(1);
            end else begin
              out_col <= out_col + bmf_pkg::COL_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!results.valid || results.ready)) |=> results.valid)
    else $error("result not loaded");

  a_rd_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (dr < win_n && dc < win_n))
    else $error("window index out of range");

  a_wr_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> (mod_rem < eff_k))
    else $error("row slot out of range");

  a_rd_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDW) |-> rd_pend)
    else $error("last window read lost");

endmodule
